// ----- sv/bfa_pkg.sv -----
// shared types and constants of the best-fit block allocator
`default_nettype none
package bfa_pkg;

  localparam int unsigned AddrW = 24;
  localparam int unsigned AlignMin = 5;
  localparam int unsigned AlignMax = 12;

  typedef enum logic [1:0] {
    KIND_SPARE = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USED  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_BAD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNSET   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_SHORT   = 3'd3,
    ST_NOFIT   = 3'd4,
    ST_NODESC  = 3'd5,
    ST_MISALGN = 3'd6,
    ST_UNKNOWN = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    REG_ALIGN    = 2'd0,
    REG_HEAP     = 2'd1,
    REG_COALESCE = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_APPLY,
    S_PREV,
    S_NEXT,
    S_SETTLE,
    S_MERGE,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic clr_start; // reset scan counter and results
    logic clr_step;  // write spare/seed entry at counter
    logic scan;      // one alloc/lookup scan step
    logic prev_scan; // one coalesce step, previous neighbour
    logic next_scan; // one coalesce step, next neighbour
    logic apply;     // commit alloc or free
    logic merge;     // commit merge
    logic finish;    // set result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic early_done; // result already decided before scan
    logic is_alloc;
    logic prev_hit;
    logic next_hit;
    logic coalesce;
    logic free_ok;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/bfa_ctrl.sv -----
// sequencing state machine of the allocator
`default_nettype none
module bfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_i,
  input  wire logic          reinit_i,
  input  wire logic          out_busy_i,
  input  wire bfa_pkg::stat_t stat_i,
  output bfa_pkg::cmd_t      cmd_o,
  output logic               ready_o,
  output logic               done_o
);

  bfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ready_o = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      bfa_pkg::S_IDLE: begin
        if (reinit_i) begin
          state_d = bfa_pkg::S_CLEAR;
          cmd_o.clr_start = 1'b1;
        end else begin
          ready_o = !out_busy_i;
          if (req_i && !out_busy_i) begin
            cmd_o.load = 1'b1;
            state_d = bfa_pkg::S_CHECK;
          end
        end
      end
      bfa_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.scan_last) state_d = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_CHECK: begin
        cmd_o.clr_start = 1'b1;
        state_d = stat_i.early_done ? bfa_pkg::S_DONE : bfa_pkg::S_SCAN;
      end
      bfa_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = bfa_pkg::S_DECIDE;
      end
      bfa_pkg::S_DECIDE: begin
        state_d = bfa_pkg::S_APPLY;
      end
      bfa_pkg::S_APPLY: begin
        cmd_o.apply = 1'b1;
        cmd_o.clr_start = 1'b1;
        if (!stat_i.is_alloc && stat_i.free_ok && stat_i.coalesce) state_d = bfa_pkg::S_PREV;
        else state_d = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_PREV: begin
        cmd_o.prev_scan = 1'b1;
        if (stat_i.scan_last) state_d = bfa_pkg::S_NEXT;
      end
      bfa_pkg::S_NEXT: begin
        if (stat_i.prev_hit) begin
          state_d = bfa_pkg::S_MERGE;
        end else begin
          cmd_o.next_scan = 1'b1;
          if (stat_i.scan_last) state_d = bfa_pkg::S_SETTLE;
        end
      end
      bfa_pkg::S_SETTLE: begin
        // last next-neighbour entry is evaluated here
        state_d = bfa_pkg::S_MERGE;
      end
      bfa_pkg::S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_DONE: begin
        cmd_o.finish = 1'b1;
        done_o = 1'b1;
        state_d = bfa_pkg::S_IDLE;
      end
      default: state_d = bfa_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/bfa_dpath.sv -----
// descriptor table, scan logic and tallies of the allocator
`default_nettype none
module bfa_dpath #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bfa_pkg::cmd_t               cmd_i,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [bfa_pkg::AddrW-1:0]   count_i,
  input  wire logic [bfa_pkg::AddrW-1:0]   addr_i,
  input  wire logic [3:0]                  align_i,
  input  wire logic [bfa_pkg::AddrW-1:0]   heap_i,
  input  wire logic                        coalesce_i,
  output bfa_pkg::stat_t                   stat_o,
  output logic [2:0]                       status_o,
  output logic [bfa_pkg::AddrW-1:0]        raddr_o,
  output logic                             in_heap_o,
  output logic [bfa_pkg::AddrW-1:0]        free_o,
  output logic [bfa_pkg::AddrW-1:0]        used_o
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned AW = bfa_pkg::AddrW;
  localparam int unsigned SW = bfa_pkg::AddrW + 1;

  // descriptor memory: kind, start, size
  typedef struct packed {
    logic [1:0]    kind;
    logic [AW-1:0] start;
    logic [SW-1:0] size;
  } desc_t;

  desc_t mem [MAX_BLOCKS];

  logic [IdxW:0]   cnt_q;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] rd_idx;
  desc_t           rd_q;
  logic            rd_ok_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            we;
  logic [IdxW-1:0] wa;
  desc_t           wd;

  logic [1:0]    mode_q;
  logic [SW-1:0] need_q;
  logic [AW-1:0] addr_q;
  logic [SW-1:0] gran;
  logic [SW-1:0] data_sz;

  logic            best_v_q, spare_v_q;
  logic [IdxW-1:0] best_q, spare_q;
  desc_t           best_d_q;
  logic            nb_v_q;
  logic [IdxW-1:0] nb_q;
  desc_t           nb_d_q;
  desc_t           hit_d_q;
  logic            ok_q;
  logic            split_q, merged_q;
  logic            ev_prev_seen_q;
  logic            apply_ok;

  logic [2:0]          status_q;
  logic [AW-1:0]       raddr_q;
  logic                inh_q;
  logic [SW-1:0]       free_q, used_q;
  logic                early;
  logic                early_q;
  logic [2:0]          early_st;

  logic [3:0] lg;
  always_comb begin
    lg = align_i;
    if (lg < 4'(bfa_pkg::AlignMin)) lg = 4'(bfa_pkg::AlignMin);
    if (lg > 4'(bfa_pkg::AlignMax)) lg = 4'(bfa_pkg::AlignMax);
    gran = SW'(1) << lg;
    data_sz = {1'b0, heap_i} & ~(gran - SW'(1));
  end

  assign idx = cnt_q[IdxW-1:0];
  assign stat_o.scan_last = (cnt_q == (IdxW+1)'(MAX_BLOCKS - 1));
  assign stat_o.is_alloc = (mode_q == bfa_pkg::MODE_ALLOC);
  assign stat_o.prev_hit = nb_v_q;
  assign stat_o.next_hit = nb_v_q;
  assign stat_o.coalesce = coalesce_i;
  assign stat_o.free_ok = best_v_q;
  assign stat_o.early_done = early;

  // checks that need no table scan
  always_comb begin
    early = 1'b1;
    early_st = bfa_pkg::ST_OK;
    if (mode_q == bfa_pkg::MODE_BAD) early_st = bfa_pkg::ST_UNKNOWN;
    else if (heap_i == '0) early_st = bfa_pkg::ST_UNSET;
    else if (mode_q == bfa_pkg::MODE_QUERY) early_st = bfa_pkg::ST_OK;
    else if (mode_q == bfa_pkg::MODE_ALLOC) begin
      if (need_q == '0) early_st = bfa_pkg::ST_ZERO;
      else if (need_q > free_q) early_st = bfa_pkg::ST_SHORT;
      else early = 1'b0;
    end else begin
      if ((SW'(addr_q) & (gran - SW'(1))) != '0) early_st = bfa_pkg::ST_MISALGN;
      else early = 1'b0;
    end
  end

  // commit only when the table really changes: a hit, and a spare for any split
  always_comb begin
    apply_ok = best_v_q;
    if (mode_q == bfa_pkg::MODE_ALLOC && best_d_q.size > need_q && !spare_v_q)
      apply_ok = 1'b0;
  end

  // memory read address runs one ahead of the evaluated entry
  assign rd_idx = idx;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_idx];
    rd_idx_q <= rd_idx;
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ok_q <= 1'b0;
    else rd_ok_q <= cmd_i.scan | cmd_i.prev_scan | cmd_i.next_scan;
  end

  // evaluate the entry read in the previous cycle
  logic [AW-1:0] hend, jend;
  always_comb begin
    hend = AW'(SW'(hit_d_q.start) + hit_d_q.size);
    jend = AW'(SW'(rd_q.start) + rd_q.size);
  end

  logic ev_prev_q, ev_next_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_prev_q <= 1'b0;
      ev_next_q <= 1'b0;
    end else begin
      ev_prev_q <= cmd_i.prev_scan;
      ev_next_q <= cmd_i.next_scan;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = '0;
    if (cmd_i.clr_step) begin
      we = 1'b1;
      wa = idx;
      if (idx == '0 && data_sz != '0) begin
        wd.kind = bfa_pkg::KIND_FREE;
        wd.size = data_sz;
      end
    end else if (cmd_i.apply && apply_ok) begin
      we = 1'b1;
      wa = best_q;
      wd = best_d_q;
      if (mode_q == bfa_pkg::MODE_ALLOC) begin
        wd.kind = bfa_pkg::KIND_USED;
        wd.size = need_q;
      end else begin
        wd.kind = bfa_pkg::KIND_FREE;
      end
    end else if (cmd_i.merge && nb_v_q) begin
      we = 1'b1;
      wa = nb_q;
      wd = '0;
    end else if (cmd_i.finish && mode_q == bfa_pkg::MODE_ALLOC && ok_q && split_q) begin
      we = 1'b1;
      wa = spare_q;
      wd.kind = bfa_pkg::KIND_FREE;
      wd.start = AW'(SW'(best_d_q.start) + need_q);
      wd.size = best_d_q.size - need_q;
    end else if (cmd_i.finish && merged_q) begin
      we = 1'b1;
      wa = best_q;
      wd = hit_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      mode_q <= bfa_pkg::MODE_BAD;
      best_v_q <= 1'b0;
      spare_v_q <= 1'b0;
      nb_v_q <= 1'b0;
      ok_q <= 1'b0;
      split_q <= 1'b0;
      merged_q <= 1'b0;
      early_q <= 1'b0;
      status_q <= bfa_pkg::ST_OK;
      raddr_q <= '0;
      inh_q <= 1'b0;
      free_q <= '0;
      used_q <= '0;
      best_q <= '0;
      spare_q <= '0;
      nb_q <= '0;
    end else begin
      if (cmd_i.load) begin
        mode_q <= mode_i;
        need_q <= (SW'(count_i) + gran - SW'(1)) & ~(gran - SW'(1));
        addr_q <= AW'(addr_i);
        ok_q <= 1'b0;
        split_q <= 1'b0;
        merged_q <= 1'b0;
      end
      if (cmd_i.clr_start) begin
        cnt_q <= '0;
        nb_v_q <= 1'b0;
        if (!cmd_i.apply) begin
          best_v_q <= 1'b0;
          spare_v_q <= 1'b0;
          // decision taken at the check step, kept for the finishing step
          early_q <= early;
        end
      end else if (cmd_i.clr_step || cmd_i.scan || cmd_i.prev_scan || cmd_i.next_scan) begin
        cnt_q <= stat_o.scan_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        free_q <= data_sz;
        used_q <= '0;
      end
      // scan evaluation of last read entry
      if (rd_ok_q && !ev_prev_q && !ev_next_q) begin
        if (rd_q.kind == bfa_pkg::KIND_SPARE && !spare_v_q) begin
          spare_v_q <= 1'b1;
          spare_q <= rd_idx_q;
        end
        if (mode_q == bfa_pkg::MODE_ALLOC) begin
          if (rd_q.kind == bfa_pkg::KIND_FREE && rd_q.size >= need_q &&
              (!best_v_q || rd_q.size < best_d_q.size ||
               (rd_q.size == best_d_q.size && rd_q.start < best_d_q.start))) begin
            best_v_q <= 1'b1;
            best_q <= rd_idx_q;
            best_d_q <= rd_q;
          end
        end else if (rd_q.kind == bfa_pkg::KIND_USED && rd_q.start == addr_q &&
                     !best_v_q) begin
          best_v_q <= 1'b1;
          best_q <= rd_idx_q;
          best_d_q <= rd_q;
        end
      end
      if (rd_ok_q && (ev_prev_q || ev_next_q) && !nb_v_q && rd_idx_q != best_q &&
          rd_q.kind == bfa_pkg::KIND_FREE &&
          (ev_prev_q ? (jend == hit_d_q.start) : (rd_q.start == hend))) begin
        nb_v_q <= 1'b1;
        nb_q <= rd_idx_q;
        nb_d_q <= rd_q;
      end
      if (cmd_i.apply) begin
        hit_d_q <= {bfa_pkg::KIND_FREE, best_d_q.start, best_d_q.size};
        if (mode_q == bfa_pkg::MODE_ALLOC) begin
          if (!best_v_q) status_q <= bfa_pkg::ST_NOFIT;
          else if (best_d_q.size > need_q && !spare_v_q) status_q <= bfa_pkg::ST_NODESC;
          else begin
            status_q <= bfa_pkg::ST_OK;
            ok_q <= 1'b1;
            split_q <= best_d_q.size > need_q;
            free_q <= free_q - need_q;
            used_q <= used_q + need_q;
          end
        end else if (!best_v_q) begin
          status_q <= bfa_pkg::ST_UNKNOWN;
        end else begin
          status_q <= bfa_pkg::ST_OK;
          used_q <= used_q - best_d_q.size;
          free_q <= free_q + best_d_q.size;
        end
      end
      if (cmd_i.merge && nb_v_q) begin
        merged_q <= 1'b1;
        hit_d_q <= {hit_d_q.kind, ev_prev_seen_q ? nb_d_q.start : hit_d_q.start,
                    hit_d_q.size + nb_d_q.size};
      end
      if (cmd_i.finish) begin
        if (early_q) status_q <= early_st;
        inh_q <= (mode_q == bfa_pkg::MODE_QUERY) && heap_i != '0 && addr_q < heap_i;
        raddr_q <= (ok_q && !early_q) ? best_d_q.start : '0;
      end
    end
  end

  // remembers whether the neighbour came from the previous-block pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ev_prev_seen_q <= 1'b0;
    else if (cmd_i.clr_start) ev_prev_seen_q <= 1'b0;
    else if (rd_ok_q && ev_prev_q && !nb_v_q && rd_idx_q != best_q &&
             rd_q.kind == bfa_pkg::KIND_FREE && jend == hit_d_q.start)
      ev_prev_seen_q <= 1'b1;
  end

  assign status_o = (cmd_i.finish && early_q) ? early_st : status_q;
  assign raddr_o = raddr_q;
  assign in_heap_o = inh_q;
  assign free_o = free_q[bfa_pkg::AddrW-1:0];
  assign used_o = used_q[bfa_pkg::AddrW-1:0];

endmodule
`default_nettype wire

// ----- sv/best_fit_block_allocator.sv -----
// top level of the best-fit block allocator with one-step coalescing
// Each transfer on s_axis is one request (allocate, free or range query) and
// yields exactly one result transfer on m_axis. Requests are handled one at a
// time: a request that needs the descriptor table takes one pass over all
// MAX_BLOCKS entries through the single read port of the table memory, plus a
// second pass for the previous neighbour when a free coalesces, and a third for
// the next neighbour if the second finds none. Requests settled without the
// table (unset heap, zero size, short, misaligned, query, unknown mode) skip
// these passes. After reset and after a write to align_log2 or heap_bytes the
// table is rebuilt by a clearing pass over all MAX_BLOCKS entries, taking no
// request meanwhile; a write during a request before its apply step can be lost.
// The result sits in an output register; no new request is taken while it waits.
`default_nettype none
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // mode[1:0], byte_count[25:2], address[49:26]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0] m_axis_tdata, // status, result_address, in_heap, free_bytes, used_bytes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  // configuration registers
  logic [3:0]  align_q;
  logic [23:0] heap_q;
  logic        coal_q;
  logic        reinit_q;
  logic        reinit_clr;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= 4'd7;
      heap_q <= 24'd1048576;
      coal_q <= 1'b1;
      reinit_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_i)
          bfa_pkg::REG_ALIGN: begin
            align_q <= cfg_data_i[3:0];
            reinit_q <= 1'b1;
          end
          bfa_pkg::REG_HEAP: begin
            heap_q <= cfg_data_i;
            reinit_q <= 1'b1;
          end
          bfa_pkg::REG_COALESCE: coal_q <= cfg_data_i[0];
          default: ;
        endcase
      end else if (reinit_clr) begin
        reinit_q <= 1'b0;
      end
    end
  end

  bfa_pkg::cmd_t  cmd;
  bfa_pkg::stat_t stat;
  logic           done, ready;
  logic [2:0]     status;
  logic [23:0]    raddr, fb, ub;
  logic           inh;
  logic           ovalid_q;
  logic [79:0]    odata_q;
  logic           done_q;
  logic [2:0]     st_q;

  // cleared at clearing pass start, check and apply; a write in a clearing pass runs another
  assign reinit_clr = cmd.clr_start;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (s_axis_tvalid),
    .reinit_i   (reinit_q),
    .out_busy_i (ovalid_q || done_q),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .ready_o    (ready),
    .done_o     (done)
  );

  bfa_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (s_axis_tdata[1:0]),
    .count_i    (s_axis_tdata[25:2]),
    .addr_i     (s_axis_tdata[49:26]),
    .align_i    (align_q),
    .heap_i     (heap_q),
    .coalesce_i (coal_q),
    .stat_o     (stat),
    .status_o   (status),
    .raddr_o    (raddr),
    .in_heap_o  (inh),
    .free_o     (fb),
    .used_o     (ub)
  );

  assign s_axis_tready = ready;

  // result register, loaded through done_q after the finishing step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      done_q <= done;
      if (done_q) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) st_q <= status;
    if (done_q) odata_q <= {4'd0, ub, fb, inh, raddr, st_q};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

endmodule
`default_nettype wire

// ----- sv/bfa_checker.sv -----
// port-level checks of the allocator and their binding
`default_nettype none
module bfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result appeared too early");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[79:76] == 4'd0)
    else $error("padding bits set");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- dv/best_fit_block_allocator_test.sv -----
// self-checking testbench for the best-fit block allocator
`timescale 1ns / 100ps
`default_nettype none
module best_fit_block_allocator_test;
  import bfa_pkg::*;

  localparam int unsigned NumBlocks = 64;
  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    mode_e       mode;
    logic [23:0] byte_count;
    logic [23:0] address;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] result_address;
    logic        in_heap;
    logic [23:0] free_bytes;
    logic [23:0] used_bytes;
  } response_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  best_fit_block_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of the descriptor table, tallies and registers
  kind_e       blk_kind [NumBlocks];
  logic [23:0] blk_start[NumBlocks];
  logic [23:0] blk_size [NumBlocks];
  logic [23:0] free_tally, used_tally;
  logic [3:0]  align_reg = 4'd7;
  logic [23:0] heap_reg = 24'd1048576;
  logic        coalesce_reg = 1'b1;

  request_t  pending_reqs[$];
  response_t awaited_results[$];
  int        errors = 0;
  bit        calm = 1'b0;   // no idling at all while set

  function automatic int unsigned granule();
    int unsigned lg;
    lg = align_reg;
    if (lg < AlignMin) lg = AlignMin;
    if (lg > AlignMax) lg = AlignMax;
    return 32'd1 << lg;
  endfunction

  task automatic rebuild_heap();
    int unsigned data;
    data = heap_reg & ~(granule() - 1);
    for (int i = 0; i < NumBlocks; i++) begin
      blk_kind[i] = KIND_SPARE;
      blk_start[i] = '0;
      blk_size[i] = '0;
    end
    free_tally = data[23:0];
    used_tally = '0;
    if (data != 0) begin
      blk_kind[0] = KIND_FREE;
      blk_size[0] = data[23:0];
    end
  endtask

  // best fit, lowest start on a tie, split the remainder into a spare entry
  task automatic allocate_block(input logic [23:0] cnt, output status_e st,
                                output logic [23:0] addr);
    int unsigned g, need;
    int best, spare;
    g = granule();
    need = (32'(cnt) + g - 1) & ~(g - 1);
    best = -1;
    spare = -1;
    addr = '0;
    if (cnt == 0) begin
      st = ST_ZERO;
      return;
    end
    if (32'(free_tally) < need) begin
      st = ST_SHORT;
      return;
    end
    for (int i = 0; i < NumBlocks; i++) begin
      if (blk_kind[i] == KIND_FREE && 32'(blk_size[i]) >= need) begin
        if (best < 0 || blk_size[i] < blk_size[best] ||
            (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best]))
          best = i;
      end
    end
    if (best < 0) begin
      st = ST_NOFIT;
      return;
    end
    if (32'(blk_size[best]) > need) begin
      for (int i = NumBlocks - 1; i >= 0; i--)
        if (blk_kind[i] == KIND_SPARE) spare = i;
      if (spare < 0) begin
        st = ST_NODESC;
        return;
      end
      blk_kind[spare] = KIND_FREE;
      blk_start[spare] = blk_start[best] + need[23:0];
      blk_size[spare] = blk_size[best] - need[23:0];
      blk_size[best] = need[23:0];
    end
    blk_kind[best] = KIND_USED;
    free_tally -= need[23:0];
    used_tally += need[23:0];
    addr = blk_start[best];
    st = ST_OK;
  endtask

  // mark used block free, then at most one merge: previous neighbour first
  task automatic release_block(input logic [23:0] addr, output status_e st);
    int hit;
    hit = -1;
    if ((32'(addr) & (granule() - 1)) != 0) begin
      st = ST_MISALGN;
      return;
    end
    for (int i = NumBlocks - 1; i >= 0; i--)
      if (blk_kind[i] == KIND_USED && blk_start[i] == addr) hit = i;
    if (hit < 0) begin
      st = ST_UNKNOWN;
      return;
    end
    st = ST_OK;
    blk_kind[hit] = KIND_FREE;
    used_tally -= blk_size[hit];
    free_tally += blk_size[hit];
    if (!coalesce_reg) return;
    for (int j = 0; j < NumBlocks; j++) begin
      if (j != hit && blk_kind[j] == KIND_FREE &&
          32'(blk_start[j]) + 32'(blk_size[j]) == 32'(blk_start[hit])) begin
        blk_start[hit] = blk_start[j];
        blk_size[hit] += blk_size[j];
        blk_kind[j] = KIND_SPARE;
        blk_start[j] = '0;
        blk_size[j] = '0;
        return;
      end
    end
    for (int j = 0; j < NumBlocks; j++) begin
      if (j != hit && blk_kind[j] == KIND_FREE &&
          32'(blk_start[j]) == 32'(blk_start[hit]) + 32'(blk_size[hit])) begin
        blk_size[hit] += blk_size[j];
        blk_kind[j] = KIND_SPARE;
        blk_start[j] = '0;
        blk_size[j] = '0;
        return;
      end
    end
  endtask

  task automatic predict_request(input request_t r, output response_t e);
    status_e     st;
    logic [23:0] ra;
    st = ST_OK;
    ra = '0;
    e.in_heap = 1'b0;
    if (r.mode == MODE_BAD) st = ST_UNKNOWN;
    else if (heap_reg == 0) st = ST_UNSET;
    else if (r.mode == MODE_ALLOC) allocate_block(r.byte_count, st, ra);
    else if (r.mode == MODE_FREE) release_block(r.address, st);
    else e.in_heap = (r.address < heap_reg);
    e.status = st;
    e.result_address = ra;
    e.free_bytes = free_tally;
    e.used_bytes = used_tally;
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 87) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // request driver
  int src_gap = 0;
  always @(posedge clk_i) begin
    request_t  nxt;
    response_t e;
    logic      drive;
    drive = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_request(request_t'({s_axis_tdata[1:0], s_axis_tdata[25:2],
                                  s_axis_tdata[49:26]}), e);
      awaited_results.push_back(e);
      drive = 1'b0;
      src_gap = gap_len();
    end
    if (!drive && rst_ni) begin
      if (src_gap > 0) src_gap--;
      else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        s_axis_tdata <= {6'b0, nxt.address, nxt.byte_count, nxt.mode};
        drive = 1'b1;
      end
    end
    s_axis_tvalid <= drive;
  end

  // result monitor and receiver stalls
  int sink_gap = 0;
  always @(posedge clk_i) begin
    response_t e, act;
    if (m_axis_tvalid && m_axis_tready) begin
      act.status = status_e'(m_axis_tdata[2:0]);
      act.result_address = m_axis_tdata[26:3];
      act.in_heap = m_axis_tdata[27];
      act.free_bytes = m_axis_tdata[51:28];
      act.used_bytes = m_axis_tdata[75:52];
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, actual %p", $time, act);
      end else begin
        e = awaited_results.pop_front();
        if (act.status != e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
        end
        if (act.result_address != e.result_address) begin
          errors++;
          $display("%0t: result_address expected %h actual %h", $time,
                   e.result_address, act.result_address);
        end
        if (act.in_heap != e.in_heap) begin
          errors++;
          $display("%0t: in_heap expected %0d actual %0d", $time, e.in_heap, act.in_heap);
        end
        if (act.free_bytes != e.free_bytes) begin
          errors++;
          $display("%0t: free_bytes expected %h actual %h", $time,
                   e.free_bytes, act.free_bytes);
        end
        if (act.used_bytes != e.used_bytes) begin
          errors++;
          $display("%0t: used_bytes expected %h actual %h", $time,
                   e.used_bytes, act.used_bytes);
        end
      end
      sink_gap = gap_len();
    end
    if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() > 0 || s_axis_tvalid || awaited_results.size() > 0);
  endtask

  task automatic write_reg(input reg_e idx, input logic [23:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ALIGN: begin
        align_reg = val[3:0];
        rebuild_heap();
      end
      REG_HEAP: begin
        heap_reg = val;
        rebuild_heap();
      end
      REG_COALESCE: begin
        coalesce_reg = val[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_req(input mode_e m, input logic [23:0] cnt, input logic [23:0] addr);
    pending_reqs.push_back('{mode: m, byte_count: cnt, address: addr});
  endtask

  // random requests, generated in short batches so that frees target live blocks
  task automatic run_traffic(input int count);
    int           n, pick;
    int unsigned  r, g;
    logic [23:0]  live[$];
    n = 0;
    while (n < count) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      g = granule();
      live.delete();
      for (int i = 0; i < NumBlocks; i++)
        if (blk_kind[i] == KIND_USED) live.push_back(blk_start[i]);
      for (int k = 0; k < 8; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          if ($urandom_range(0, 9) == 0) push_req(MODE_ALLOC, 24'($urandom), 24'($urandom));
          else push_req(MODE_ALLOC, 24'($urandom_range(1, 4 * g)), 24'($urandom));
        end else if (r < 82 && live.size() > 0) begin
          pick = $urandom_range(0, live.size() - 1);
          push_req(MODE_FREE, 24'($urandom), live[pick]);
          live.delete(pick);
        end else if (r < 88) begin
          push_req(MODE_FREE, 24'($urandom), 24'($urandom));
        end else if (r < 96) begin
          push_req(MODE_QUERY, 24'($urandom), ($urandom_range(0, 1) == 0) ?
                   24'($urandom) : heap_reg - 24'($urandom_range(0, 1)));
        end else begin
          push_req(MODE_BAD, 24'($urandom), 24'($urandom));
        end
        n++;
      end
    end
  endtask

  initial begin
    rebuild_heap();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and the special cases that the reset heap can show
    push_req(MODE_QUERY, 24'h0, 24'h0);
    push_req(MODE_QUERY, 24'hFFFFFF, 24'd1048575);
    push_req(MODE_QUERY, 24'h0, 24'd1048576);
    push_req(MODE_QUERY, 24'h0, 24'hFFFFFF);
    push_req(MODE_BAD, 24'hFFFFFF, 24'hFFFFFF);
    push_req(MODE_ALLOC, 24'h0, 24'h0);
    push_req(MODE_ALLOC, 24'hFFFFFF, 24'h0);
    push_req(MODE_ALLOC, 24'd1, 24'h0);
    push_req(MODE_ALLOC, 24'd200, 24'h0);
    push_req(MODE_FREE, 24'h0, 24'd1);
    push_req(MODE_FREE, 24'h0, 24'hFFFFFF);
    push_req(MODE_FREE, 24'h0, 24'h800);
    push_req(MODE_FREE, 24'h0, 24'h0);
    push_req(MODE_FREE, 24'h0, 24'd128);
    // free space is whole but split in two blocks: no fit for the whole heap, a fit just below it
    push_req(MODE_ALLOC, 24'd1048576, 24'h0);
    push_req(MODE_ALLOC, 24'd1048000, 24'h0);

    // heap not set up: every mode but the unknown one reports unset
    write_reg(REG_HEAP, 24'h0);
    push_req(MODE_ALLOC, 24'd64, 24'h0);
    push_req(MODE_FREE, 24'h0, 24'h0);
    push_req(MODE_QUERY, 24'h0, 24'h0);
    push_req(MODE_BAD, 24'h0, 24'h0);

    // out-of-range index is ignored
    write_reg(reg_e'(2'd3), 24'hFFFFFF);

    // small heap, smallest granule, no merge: runs out of descriptors
    write_reg(REG_ALIGN, 24'd5);
    write_reg(REG_HEAP, 24'd4096);
    write_reg(REG_COALESCE, 24'd0);
    for (int i = 0; i < 66; i++) push_req(MODE_ALLOC, 24'd32, 24'h0);
    run_traffic(110);

    write_reg(REG_COALESCE, 24'd1);
    run_traffic(150);

    // largest granule and largest heap
    write_reg(REG_ALIGN, 24'd12);
    write_reg(REG_HEAP, 24'hFFFFFF);
    run_traffic(100);

    // heap size not a multiple of the granule
    write_reg(REG_ALIGN, 24'd6);
    write_reg(REG_HEAP, 24'd10000);
    write_reg(REG_COALESCE, 24'd0);
    run_traffic(150);

    // alignment codes outside the clamp range
    write_reg(REG_ALIGN, 24'd15);
    write_reg(REG_HEAP, 24'd65536);
    write_reg(REG_COALESCE, 24'd1);
    run_traffic(100);

    write_reg(REG_ALIGN, 24'd0);
    write_reg(REG_HEAP, 24'd3000);
    run_traffic(100);

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
